// File: hdl/ism_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types.
package ism_pkg;

    localparam int CMD_W    = 4;
    localparam int DATA_W   = 32;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_CONST = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_MAX   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MIN   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NEG   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_DUP   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic load;      // capture the accepted instruction
        logic exec;      // check faults, compute the result, start the divider
        logic div_take;  // capture the signed quotient
        logic commit;    // update the stack and load the output register
    } ism_ctrl_t;

    typedef struct packed {
        logic div_go;    // valid during exec: a division without fault
        logic div_done;  // quotient ready
    } ism_stat_t;

endpackage

// File: hdl/integer_stack_machine_core.sv
// Top level of the 32-bit integer stack machine.
//
// One instruction per input transaction on the s_ channel; one result per
// instruction on the m_ channel (top of stack, depth, status).
// Input tdata: cmd [3:0], operand [35:4]. Output tdata: top_value [31:0],
// stack_depth [38:32], status [40:39].
// Instructions run one at a time: accept, execute, commit; the next
// instruction is accepted only after the previous one commits. DIV adds a
// wait in which the divider produces one quotient bit per cycle, then a
// step to take the quotient before the commit.
// The top of stack sits in a register; deeper entries sit in a RAM with a
// registered read port, read ahead while the machine waits for input.
// Faults (underflow, overflow, divide by zero) leave the stack unchanged.
// Reset empties the stack; RAM contents are left as they are.
// The result sits in an output register; the next instruction is accepted
// while it waits. A stalled receiver holds the machine in commit until the
// output register frees up.
module integer_stack_machine_core
    import ism_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // cmd [3:0], operand [35:4], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // top_value [31:0], stack_depth [38:32], status [40:39]
);

    ism_ctrl_t           ctl;
    ism_stat_t           stat;
    logic [DATA_W-1:0]   out_top;
    logic [DEPTH_W-1:0]  out_depth;
    logic [STATUS_W-1:0] out_status;

    ism_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    ism_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_cmd     (s_tdata[3:0]),
        .in_operand (s_tdata[35:4]),
        .out_top    (out_top),
        .out_depth  (out_depth),
        .out_status (out_status)
    );

    assign m_tdata = {7'd0, out_status, out_depth, out_top};

endmodule

// File: hdl/ism_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ism_div.sv
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module ism_div
    import ism_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when it does not go negative
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hdl/ism_dp.sv
// Datapath: top-of-stack register, stack RAM, ALU, divider and result register.
module ism_dp
    import ism_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ism_ctrl_t           ctl,
    output ism_stat_t           stat,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [DATA_W-1:0]   in_operand,
    output logic [DATA_W-1:0]   out_top,
    output logic [DEPTH_W-1:0]  out_depth,
    output logic [STATUS_W-1:0] out_status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   opnd_reg;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [DATA_W-1:0]   tos_reg, tos_next;
    logic [DATA_W-1:0]   r_reg, r_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                negq_reg;
    logic [DATA_W-1:0]   out_top_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       raddr;
    logic [DATA_W-1:0]   b_val;
    logic [DATA_W-1:0]   mul_lo;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic                div_done;
    logic [DATA_W-1:0]   quo;
    logic                empty;
    logic                below_two;
    logic                full;

    // entry below the top lives in RAM at sp-2; the top stays in tos_reg
    assign raddr = AW'(sp_reg - SPW'(2));

    ism_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (tos_reg),
        .raddr (raddr),
        .rdata (b_val)
    );

    assign mag_a = tos_reg[DATA_W-1] ? (DATA_W'(0) - tos_reg) : tos_reg;
    assign mag_b = b_val[DATA_W-1] ? (DATA_W'(0) - b_val) : b_val;

    ism_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.exec && stat.div_go),
        .dividend (mag_a),
        .divisor  (mag_b),
        .done     (div_done),
        .quotient (quo)
    );

    assign mul_lo    = tos_reg * b_val;
    assign empty     = (sp_reg == '0);
    assign below_two = (sp_reg < SPW'(2));
    assign full      = (sp_reg == SPW'(STACK_DEPTH));

    // fault check and result value
    always_comb
    begin
        status_next = ST_OK;
        r_next      = tos_reg;
        unique case (cmd_reg) inside
            CMD_CONST:
            begin
                if (full)
                    status_next = ST_OVER;
                r_next = opnd_reg;
            end
            CMD_DUP:
            begin
                if (empty)
                    status_next = ST_UNDER;
                else if (full)
                    status_next = ST_OVER;
            end
            CMD_NEG:
            begin
                if (empty)
                    status_next = ST_UNDER;
                r_next = DATA_W'(0) - tos_reg;
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN:
            begin
                if (below_two)
                    status_next = ST_UNDER;
                else if (cmd_reg == CMD_DIV && b_val == '0)
                    status_next = ST_DIVZ;
                case (cmd_reg)
                    CMD_SWAP: r_next = b_val;
                    CMD_ADD:  r_next = tos_reg + b_val;
                    CMD_SUB:  r_next = tos_reg - b_val;
                    CMD_MUL:  r_next = mul_lo;
                    CMD_MAX:  r_next = ($signed(tos_reg) > $signed(b_val)) ? tos_reg : b_val;
                    CMD_MIN:  r_next = ($signed(b_val) > $signed(tos_reg)) ? tos_reg : b_val;
                    default:  r_next = tos_reg;
                endcase
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign stat.div_go   = (cmd_reg == CMD_DIV) && (status_next == ST_OK);
    assign stat.div_done = div_done;

    // stack update on commit
    always_comb
    begin
        sp_next  = sp_reg;
        tos_next = tos_reg;
        we       = 1'b0;
        waddr    = AW'(sp_reg - SPW'(1));
        if (ctl.commit && status_reg == ST_OK)
        begin
            unique case (cmd_reg) inside
                CMD_CONST:
                begin
                    we       = !empty;
                    tos_next = r_reg;
                    sp_next  = sp_reg + SPW'(1);
                end
                CMD_DUP:
                begin
                    we      = 1'b1;
                    sp_next = sp_reg + SPW'(1);
                end
                CMD_NEG:
                begin
                    tos_next = r_reg;
                end
                CMD_SWAP:
                begin
                    we       = 1'b1;
                    waddr    = AW'(sp_reg - SPW'(2));
                    tos_next = r_reg;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN:
                begin
                    tos_next = r_reg;
                    sp_next  = sp_reg - SPW'(1);
                end
                default:
                begin
                    sp_next = sp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (ctl.load)
        begin
            cmd_reg  <= in_cmd;
            opnd_reg <= in_operand;
        end
        if (ctl.exec)
        begin
            status_reg <= status_next;
            r_reg      <= r_next;
            negq_reg   <= tos_reg[DATA_W-1] ^ b_val[DATA_W-1];
        end
        else if (ctl.div_take)
        begin
            r_reg <= negq_reg ? (DATA_W'(0) - quo) : quo;
        end
        if (ctl.commit)
        begin
            out_top_reg    <= (sp_next != '0) ? tos_next : '0;
            out_depth_reg  <= DEPTH_W'(sp_next);
            out_status_reg <= status_reg;
        end
    end

    assign out_top    = out_top_reg;
    assign out_depth  = out_depth_reg;
    assign out_status = out_status_reg;

    a_fault_holds_sp : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit && status_reg != ST_OK |=> $stable(sp_reg))
        else $error("stack pointer moved on a faulted instruction");

    a_sp_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

endmodule

// File: hdl/ism_ctrl.sv
// Controller: instruction sequencing and output handshake.
module ism_ctrl
    import ism_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  ism_stat_t stat,
    output ism_ctrl_t ctl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = stat.div_go ? S_DIV : S_COMMIT;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.div_take = 1'b1;
                    state_next   = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    ctl.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_to_exec : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted transaction did not enter execute");

    a_commit_shows : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide wait");

endmodule
